@@ sv/assert_macros.svh @@
// ----------------------------------------------------------------------------
// Assertion macros
// Concurrent assertion wrappers shared by the RTL; empty under synthesis.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Clocked check with asynchronous active-low reset disable.
`define ASSERT_CLK(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("assertion failed");

// Same, with a caller-supplied message.
`define ASSERT_CLK_MSG(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error(msg);

`else

`define ASSERT_CLK(label, clk, rst_n, prop)
`define ASSERT_CLK_MSG(label, clk, rst_n, prop, msg)

`endif

`endif

@@ sv/ple_pkg.sv @@
// ----------------------------------------------------------------------------
// ple_pkg
// Shared types and codes for the positional list engine.
// ----------------------------------------------------------------------------
package ple_pkg;

    localparam int DATA_W = 32;
    localparam int FPOS_W = 7;

    typedef enum logic [1:0] {
        ACT_INSERT = 2'd0,
        ACT_DELETE = 2'd1,
        ACT_LOCATE = 2'd2,
        ACT_NONE   = 2'd3
    } action_t;

    // Command broadcast to every cell on an accepted transfer.
    // ins/del are already qualified by the range checks.
    typedef struct packed {
        logic              ins;
        logic              del;
        logic              loc;
        logic [DATA_W-1:0] value;
    } cell_cmd_t;

    // Result wave handed from cell to cell.
    typedef struct packed {
        logic              found;
        logic [FPOS_W-1:0] idx;
        logic [DATA_W-1:0] data;
    } wave_t;

endpackage

@@ sv/ple_cell.sv @@
// ----------------------------------------------------------------------------
// ple_cell
// One list slot: holds an entry, shifts with its neighbors and forwards the
// result wave toward the end of the row.
// ----------------------------------------------------------------------------
module ple_cell #(
    parameter int IDX = 0,
    parameter int PW  = 7
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        load,
    input  ple_pkg::cell_cmd_t          cmd,
    input  logic [PW-1:0]               pos,
    input  logic [PW-1:0]               count,
    input  logic [ple_pkg::DATA_W-1:0]  left_data,
    input  logic [ple_pkg::DATA_W-1:0]  right_data,
    output logic [ple_pkg::DATA_W-1:0]  data,
    input  ple_pkg::wave_t              wave_in,
    output ple_pkg::wave_t              wave_out
);

    localparam logic [PW-1:0]                  POS_HERE = PW'(IDX + 1);
    localparam logic [ple_pkg::FPOS_W-1:0]     POS_OUT  = ple_pkg::FPOS_W'(IDX + 1);

    logic [ple_pkg::DATA_W-1:0] data_reg;
    logic [ple_pkg::DATA_W-1:0] cap_reg;
    logic                       hit_reg;
    ple_pkg::wave_t             wave_reg;
    ple_pkg::wave_t             wave_next;

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            if (cmd.ins)
            begin
                if (POS_HERE == pos)
                    data_reg <= cmd.value;
                else if (POS_HERE > pos)
                    data_reg <= left_data;
            end
            else if (cmd.del && (POS_HERE >= pos))
            begin
                data_reg <= right_data;
            end
        end
    end

    // Captured from the pre-shift contents.
    always_ff @(posedge clk)
    begin
        if (load)
            cap_reg <= (cmd.del && (POS_HERE == pos)) ? data_reg : '0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            hit_reg <= 1'b0;
        else if (load)
            hit_reg <= cmd.loc && (POS_HERE <= count) && (data_reg == cmd.value);
    end

    // First hit wins; at most one cell holds nonzero capture data.
    always_comb
    begin
        wave_next.found = wave_in.found | hit_reg;
        wave_next.idx   = wave_in.found ? wave_in.idx : (hit_reg ? POS_OUT : '0);
        wave_next.data  = wave_in.data | cap_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            wave_reg <= '0;
        else
            wave_reg <= wave_next;
    end

    assign data     = data_reg;
    assign wave_out = wave_reg;

endmodule

@@ sv/positional_list_engine.sv @@
// ----------------------------------------------------------------------------
// positional_list_engine
// Ordered list of signed 32-bit entries with insert, delete and locate.
// ----------------------------------------------------------------------------
// The list lives in a row of CAPACITY cells, one entry each. On an accepted
// transfer every cell shifts at once (insert and delete) and latches its
// compare/select flags; the result then travels one cell per cycle down the
// row into the output register, and s_tready stays low until that result
// has been loaded. The length of the cell row sets how long a request takes.
// A request can be accepted while the previous result still waits on the
// output. Inserts and deletes with an out-of-range position, inserts into
// a full list, and unused action codes return ok=0 and leave the list
// unchanged.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module positional_list_engine #(
    parameter int CAPACITY = 64
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [39:0] s_tdata,    // position[6:0], value[38:7], zero pad
    input  logic [1:0]  s_tuser,    // action[1:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [47:0] m_tdata     // ok[0], removed_value[32:1],
                                    // found_position[39:33], count[46:40], pad
);

    localparam int CW = $clog2(CAPACITY + 1);
    localparam int PW = (CW > 7) ? CW : 7;
    localparam int NW = $clog2(CAPACITY + 1);
    localparam logic [NW-1:0] SWEEP_LAST = NW'(CAPACITY);
    localparam logic [PW-1:0] CAP_P      = PW'(CAPACITY);

    logic [6:0]                  in_pos;
    logic [ple_pkg::DATA_W-1:0]  in_value;
    ple_pkg::action_t            in_action;
    logic [PW-1:0]               pos_x;

    logic                        busy_reg;
    logic [NW-1:0]               cnt_reg;
    logic [PW-1:0]               count_reg;
    logic [PW-1:0]               count_next;
    logic                        op_loc_reg;
    logic                        ok_pre_reg;
    logic [PW-1:0]               pos_reg;

    logic                        out_valid_reg;
    logic                        out_ok_reg;
    logic [ple_pkg::DATA_W-1:0]  out_removed_reg;
    logic [6:0]                  out_found_reg;
    logic [6:0]                  out_count_reg;

    logic                        accept;
    logic                        done;
    logic                        ins_ok;
    logic                        del_ok;
    ple_pkg::cell_cmd_t          cmd;

    logic [ple_pkg::DATA_W-1:0]  cell_data [CAPACITY];
    ple_pkg::wave_t              wave [CAPACITY+1];

    assign in_pos    = s_tdata[6:0];
    assign in_value  = s_tdata[38:7];
    assign in_action = ple_pkg::action_t'(s_tuser);
    assign pos_x     = PW'(in_pos);

    assign s_tready = !busy_reg;
    assign accept   = s_tvalid && s_tready;
    assign done     = busy_reg && (cnt_reg == SWEEP_LAST) && (!out_valid_reg || m_tready);

    assign ins_ok = (pos_x != '0)
                 && ({1'b0, pos_x} <= ({1'b0, count_reg} + (PW+1)'(1)))
                 && (count_reg < CAP_P);
    assign del_ok = (pos_x != '0) && (pos_x <= count_reg);

    always_comb
    begin
        cmd.ins   = 1'b0;
        cmd.del   = 1'b0;
        cmd.loc   = 1'b0;
        cmd.value = in_value;
        unique case (in_action)
            ple_pkg::ACT_INSERT: cmd.ins = accept && ins_ok;
            ple_pkg::ACT_DELETE: cmd.del = accept && del_ok;
            ple_pkg::ACT_LOCATE: cmd.loc = accept;
            default:             cmd.loc = 1'b0;
        endcase
    end

    always_comb
    begin
        count_next = count_reg;
        if (cmd.ins)
            count_next = count_reg + PW'(1);
        else if (cmd.del)
            count_next = count_reg - PW'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg   <= 1'b0;
            cnt_reg    <= '0;
            count_reg  <= '0;
            op_loc_reg <= 1'b0;
            ok_pre_reg <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                busy_reg   <= 1'b1;
                cnt_reg    <= '0;
                count_reg  <= count_next;
                op_loc_reg <= cmd.loc;
                ok_pre_reg <= cmd.ins || cmd.del;
            end
            else if (done)
            begin
                busy_reg <= 1'b0;
            end
            else if (busy_reg && (cnt_reg != SWEEP_LAST))
            begin
                cnt_reg <= cnt_reg + NW'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
            pos_reg <= pos_x;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (done)
            out_valid_reg <= 1'b1;
        else if (m_tready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (done)
        begin
            out_ok_reg      <= op_loc_reg ? wave[CAPACITY].found : ok_pre_reg;
            out_removed_reg <= wave[CAPACITY].data;
            out_found_reg   <= wave[CAPACITY].idx;
            out_count_reg   <= count_reg[6:0];
        end
    end

    assign wave[0] = '0;

    for (genvar i = 0; i < CAPACITY; i++)
    begin : g_cell
        logic [ple_pkg::DATA_W-1:0] left_d;
        logic [ple_pkg::DATA_W-1:0] right_d;

        if (i == 0)
        begin : g_first
            assign left_d = in_value;
        end
        else
        begin : g_mid
            assign left_d = cell_data[i-1];
        end

        if (i == CAPACITY - 1)
        begin : g_last
            assign right_d = cell_data[i];
        end
        else
        begin : g_inner
            assign right_d = cell_data[i+1];
        end

        ple_cell #(
            .IDX (i),
            .PW  (PW)
        ) u_cell (
            .clk        (clk),
            .rst_n      (rst_n),
            .load       (accept),
            .cmd        (cmd),
            .pos        (pos_x),
            .count      (count_reg),
            .left_data  (left_d),
            .right_data (right_d),
            .data       (cell_data[i]),
            .wave_in    (wave[i]),
            .wave_out   (wave[i+1])
        );
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {1'b0, out_count_reg, out_found_reg, out_removed_reg, out_ok_reg};

    `ASSERT_CLK_MSG(a_count_bound, clk, rst_n, count_reg <= CAP_P, "count above capacity")
    `ASSERT_CLK(a_count_only_on_accept, clk, rst_n, !accept |=> $stable(count_reg))
    `ASSERT_CLK(a_done_after_sweep, clk, rst_n, done |-> (cnt_reg == SWEEP_LAST))
    `ASSERT_CLK_MSG(a_delete_pos_ok, clk, rst_n,
        (done && !op_loc_reg && ok_pre_reg) |-> (pos_reg != '0), "bad position on success")

endmodule
